[rtl/core/three_axis_ema_window_rms_top_defines.svh]
// ----------------------------------------------------------------------------
// three_axis_ema_window_rms_top_defines
// assertion macros shared by the checker of the smoothed moving rms block
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_EMA_WINDOW_RMS_TOP_DEFINES_SVH
`define THREE_AXIS_EMA_WINDOW_RMS_TOP_DEFINES_SVH

// antecedent implies consequent in the next cycle
`define EMWR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("emwr checker: next-cycle property failed");

// antecedent implies consequent in the same cycle
`define EMWR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("emwr checker: same-cycle property failed");

`endif

[rtl/core/emwr_pkg.sv]
// ----------------------------------------------------------------------------
// emwr_pkg
// shared constants and control structs of the smoothed moving rms block
// ----------------------------------------------------------------------------
package emwr_pkg;

  // smoothing weight register, unsigned q0.16
  localparam int unsigned WEIGHT_BITS = 16;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 16'd6554;

  // quotient bits produced per divider cycle
  localparam int unsigned DIV_BITS_PER_CYCLE = 4;

  // control from the top level to one lane
  typedef struct packed {
    logic start;  // an input transfer happened, lane begins its item
    logic ack;    // result taken into the output register
  } lane_ctl_t;

  // status from one lane to the top level
  typedef struct packed {
    logic done;   // result is ready and held
  } lane_sts_t;

endpackage

[rtl/core/emwr_sqrt.sv]
// ----------------------------------------------------------------------------
// emwr_sqrt
// iterative integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module emwr_sqrt #(
  parameter int unsigned ROOT_W = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2*ROOT_W-1:0]   radicand_i,
  output logic                  done_o,
  output logic [ROOT_W-1:0]     root_o
);

  localparam int unsigned CW = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] rad_q, rad_d;
  logic [ROOT_W:0]     rem_q, rem_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                run_q, run_d;
  logic                done_q, done_d;

  logic [ROOT_W+2:0]   rem_t;
  logic [ROOT_W+2:0]   trial;

  // one restoring step on the top two radicand bits
  always_comb begin
    rem_t  = {rem_q, rad_q[2*ROOT_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CW'(ROOT_W);
      run_d  = 1'b1;
    end else if (run_q) begin
      rad_d = {rad_q[2*ROOT_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_d  = (ROOT_W+1)'(rem_t - trial);
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = (ROOT_W+1)'(rem_t);
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[rtl/core/emwr_lane.sv]
// ----------------------------------------------------------------------------
// emwr_lane
// one axis: smoothing, window ring, running square sum, mean and root
// ----------------------------------------------------------------------------
module emwr_lane #(
  parameter int unsigned WINDOW_LENGTH = 100,
  parameter int unsigned FRACTION_BITS = 8,
  parameter int unsigned SAMPLE_BITS   = 12,
  parameter int unsigned PW            = $clog2(WINDOW_LENGTH)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  emwr_pkg::lane_ctl_t                ctl_i,
  output emwr_pkg::lane_sts_t                sts_o,
  input  logic [SAMPLE_BITS-1:0]             sample_i,
  input  logic [emwr_pkg::WEIGHT_BITS-1:0]   weight_i,
  input  logic [PW-1:0]                      pos_i,
  input  logic                               full_i,
  output logic [SAMPLE_BITS+FRACTION_BITS-1:0] rms_o
);

  import emwr_pkg::*;

  localparam int unsigned SMW       = SAMPLE_BITS + FRACTION_BITS;
  localparam int unsigned SUM_W     = 2*SMW + $clog2(WINDOW_LENGTH);
  localparam int unsigned DIV_STEPS = (SUM_W + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
  localparam int unsigned DIV_W     = DIV_STEPS * DIV_BITS_PER_CYCLE;
  localparam int unsigned RW        = $clog2(WINDOW_LENGTH);
  localparam int unsigned DCW       = $clog2(DIV_STEPS + 1);
  localparam int unsigned PRW       = SMW + WEIGHT_BITS + 2;
  localparam logic [RW:0] NVAL      = (RW+1)'(WINDOW_LENGTH);

  // lane sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EMA  = 3'd1;
  localparam logic [2:0] ST_SQN  = 3'd2;
  localparam logic [2:0] ST_SQO  = 3'd3;
  localparam logic [2:0] ST_SUB  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_ROOT = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [DCW-1:0]      div_cnt_q, div_cnt_d;
  logic [SMW-1:0]      smooth_q;
  logic [SUM_W-1:0]    sum_q;
  logic [SMW-1:0]      mem_q [WINDOW_LENGTH];
  logic [SMW-1:0]      rd_q;
  logic [SMW-1:0]      gone_q;
  logic [PW-1:0]       pos_q;
  logic                full_q;
  logic signed [PRW-1:0] prod_q;
  logic [2*SMW-1:0]    sq_q;
  logic [DIV_W-1:0]    dq_q;
  logic [RW-1:0]       rem_q;
  logic [SMW-1:0]      rms_q;

  logic [SMW-1:0]          target;
  logic signed [SMW:0]     diff;
  logic signed [WEIGHT_BITS:0] weight_s;
  logic [SMW-1:0]          fresh;
  logic [DIV_W-1:0]        dq_d;
  logic [RW-1:0]           rem_d;
  logic [RW:0]             rem_t;
  logic                    sqrt_start;
  logic                    sqrt_done;
  logic [SMW-1:0]          sqrt_root;

  // smoothing step operands and update
  assign target   = {sample_i, {FRACTION_BITS{1'b0}}};
  assign diff     = $signed({1'b0, target}) - $signed({1'b0, smooth_q});
  assign weight_s = $signed({1'b0, weight_i});
  assign fresh    = smooth_q + prod_q[WEIGHT_BITS +: SMW];

  // divide by the window length, a few quotient bits per cycle
  always_comb begin
    dq_d  = dq_q;
    rem_d = rem_q;
    rem_t = '0;
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      rem_t = {rem_d, dq_d[DIV_W-1]};
      dq_d  = {dq_d[DIV_W-2:0], 1'b0};
      if (rem_t >= NVAL) begin
        rem_d    = RW'(rem_t - NVAL);
        dq_d[0]  = 1'b1;
      end else begin
        rem_d = RW'(rem_t);
      end
    end
  end

  assign sqrt_start = (state_q == ST_DIV) && (div_cnt_q == DCW'(1));

  // sequencer
  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    unique case (state_q)
      ST_IDLE: if (ctl_i.start) state_d = ST_EMA;
      ST_EMA:  state_d = ST_SQN;
      ST_SQN:  state_d = ST_SQO;
      ST_SQO:  state_d = ST_SUB;
      ST_SUB: begin
        state_d   = ST_DIV;
        div_cnt_d = DCW'(DIV_STEPS);
      end
      ST_DIV: begin
        div_cnt_d = div_cnt_q - 1'b1;
        if (div_cnt_q == DCW'(1)) state_d = ST_ROOT;
      end
      ST_ROOT: if (sqrt_done) state_d = ST_DONE;
      ST_DONE: if (ctl_i.ack) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control state, smoothing state and running square sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      div_cnt_q <= '0;
      smooth_q  <= '0;
      sum_q     <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
      if (state_q == ST_EMA) smooth_q <= fresh;
      if (state_q == ST_SQO) sum_q <= sum_q + SUM_W'(sq_q);
      if (state_q == ST_SUB) sum_q <= sum_q - SUM_W'(sq_q);
    end
  end

  // window ring, one read and one write per item
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && ctl_i.start) rd_q <= mem_q[pos_i];
    if (state_q == ST_EMA) mem_q[pos_q] <= fresh;
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && ctl_i.start) begin
      prod_q <= PRW'(weight_s * diff);
      pos_q  <= pos_i;
      full_q <= full_i;
    end
    // entries not yet written since reset read as zero
    if (state_q == ST_EMA) gone_q <= full_q ? rd_q : '0;
    if (state_q == ST_SQN) sq_q <= smooth_q * smooth_q;
    if (state_q == ST_SQO) sq_q <= gone_q * gone_q;
    if (state_q == ST_SUB) begin
      dq_q  <= DIV_W'(sum_q - SUM_W'(sq_q));
      rem_q <= '0;
    end
    if (state_q == ST_DIV) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
    if (sqrt_done) rms_q <= sqrt_root;
  end

  emwr_sqrt #(
    .ROOT_W (SMW)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (dq_d[2*SMW-1:0]),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  assign sts_o.done = (state_q == ST_DONE);
  assign rms_o      = rms_q;

endmodule

[rtl/core/three_axis_ema_window_rms_top.sv]
// ----------------------------------------------------------------------------
// three_axis_ema_window_rms_top
// three-axis smoothed moving rms over a window of accelerometer samples
//
// s_axis carries one sample per axis (x, y, z); m_axis returns one rms value
// per axis for every input transfer. ema_weight is to be written through
// cfg_we_i / cfg_wdata_i only while the block is idle; the block itself does
// not enforce this. It resets to 0.1 in q0.16. Three lanes, one per axis,
// work in lockstep; a merge stage loads their roots into one output
// register. Each result passes the smoothing step and the square sums, then
// the four-bit-per-cycle divide by WINDOW_LENGTH and the one-bit-per-cycle root.
// One item is in work at a time; s_axis_tready_o rises again as soon as the
// result sits in the output register, so the next transfer can be taken
// while that result waits. A stalled receiver holds m_axis data and valid;
// the lanes then wait with their result. Reset clears the smoothed values,
// sums, ring position and fill flag; window entries read as zero until the
// ring has wrapped once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module three_axis_ema_window_rms_top #(
  parameter int unsigned WINDOW_LENGTH = 100,
  parameter int unsigned FRACTION_BITS = 8,
  parameter int unsigned SAMPLE_BITS   = 12,
  parameter int unsigned IN_W  = ((3*SAMPLE_BITS + 7) / 8) * 8,
  parameter int unsigned OUT_W = ((3*(SAMPLE_BITS + FRACTION_BITS) + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // ema_weight register
  input  logic                             cfg_we_i,
  input  logic [emwr_pkg::WEIGHT_BITS-1:0] cfg_wdata_i,
  // fields from bit 0: sample_x, sample_y, sample_z
  input  logic [IN_W-1:0]                  s_axis_tdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // fields from bit 0: rms_x, rms_y, rms_z
  output logic [OUT_W-1:0]                 m_axis_tdata_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i
);

  import emwr_pkg::*;

  localparam int unsigned SMW   = SAMPLE_BITS + FRACTION_BITS;
  localparam int unsigned PW    = $clog2(WINDOW_LENGTH);
  localparam int unsigned LANES = 3;

  logic [WEIGHT_BITS-1:0] weight_q;
  logic [PW-1:0]          pos_q;
  logic                   full_q;
  logic                   busy_q;
  logic                   out_valid_q;
  logic [3*SMW-1:0]       out_data_q;

  logic                   in_xfer;
  logic                   load;
  logic                   all_done;
  lane_ctl_t              lane_ctl;
  lane_sts_t              lane_sts [LANES];
  logic [SMW-1:0]         lane_rms [LANES];

  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !busy_q;
  assign all_done        = lane_sts[0].done && lane_sts[1].done && lane_sts[2].done;
  assign load            = busy_q && all_done && (!out_valid_q || m_axis_tready_i);

  assign lane_ctl.start = in_xfer;
  assign lane_ctl.ack   = load;

  // weight register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RESET;
    end else if (cfg_we_i) begin
      weight_q <= cfg_wdata_i;
    end
  end

  // ring position and fill flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      full_q <= 1'b0;
    end else if (in_xfer) begin
      if (pos_q == PW'(WINDOW_LENGTH - 1)) begin
        pos_q  <= '0;
        full_q <= 1'b1;
      end else begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  // item tracking and output register handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) busy_q <= 1'b1;
      else if (load) busy_q <= 1'b0;
      if (load) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  // merge the lane results
  always_ff @(posedge clk_i) begin
    if (load) out_data_q <= {lane_rms[2], lane_rms[1], lane_rms[0]};
  end

  // one lane per axis
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    emwr_lane #(
      .WINDOW_LENGTH (WINDOW_LENGTH),
      .FRACTION_BITS (FRACTION_BITS),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .PW            (PW)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (lane_ctl),
      .sts_o    (lane_sts[g]),
      .sample_i (s_axis_tdata_i[g*SAMPLE_BITS +: SAMPLE_BITS]),
      .weight_i (weight_q),
      .pos_i    (pos_q),
      .full_i   (full_q),
      .rms_o    (lane_rms[g])
    );
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'(out_data_q);

endmodule

[rtl/core/emwr_checker.sv]
// ----------------------------------------------------------------------------
// emwr_checker
// port-level checks of the smoothed moving rms block, bound to the top level
// ----------------------------------------------------------------------------
`include "three_axis_ema_window_rms_top_defines.svh"

module emwr_checker #(
  parameter int unsigned OUT_W = 64
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic [OUT_W-1:0] m_axis_tdata_o,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // stalled result keeps valid and data
  `EMWR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)
  `EMWR_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o))

  // only one item in work: ready drops after an input transfer
  `EMWR_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_xfer, !s_axis_tready_o)

  // a result never appears right after its input transfer
  `EMWR_ASSERT_SAME(a_no_instant, clk_i, rst_ni, $past(in_xfer) && !$past(m_axis_tvalid_o), !m_axis_tvalid_o)

endmodule

bind three_axis_ema_window_rms_top emwr_checker #(
  .OUT_W (OUT_W)
) u_emwr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

[test/three_axis_ema_window_rms_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_ema_window_rms_top_tb
// self-checking bench for the three-axis smoothed moving rms block
//
// A bit-exact predictor tracks the smoothed values, the window rings and the
// sums of squares for each axis. It computes the expected rms triplet on
// every input transfer, and a checker compares each output transfer against
// it. Directed items cover the sample extremes and the weight corner values.
// Random phases run under different weights, far past one wrap of the window.
// Separate tests hold the output off for a long stretch and run back to back
// with no idling.
// ----------------------------------------------------------------------------
module three_axis_ema_window_rms_top_tb;

  import emwr_pkg::*;

  localparam int unsigned WINDOW   = 100;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned SMOOTH_W = SAMPLE_W + FRAC_W;
  localparam int unsigned IN_W     = 40;
  localparam int unsigned OUT_W    = 64;

  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT  = 60;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PRINT_LIMIT = 200;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = '1;

  typedef logic [2:0][SMOOTH_W-1:0] axis_rms_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [WEIGHT_BITS-1:0] cfg_wdata_i;
  logic [IN_W-1:0]        s_axis_tdata_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [OUT_W-1:0]       m_axis_tdata_o;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;

  // predictor state
  logic [WEIGHT_BITS-1:0] weight_q;
  logic [SMOOTH_W-1:0]    smooth_q [3];
  logic [SMOOTH_W-1:0]    ring_q   [3][WINDOW];
  logic [63:0]            sum_sq_q [3];
  int unsigned            ring_pos;

  axis_rms_t expected_rms_q [$];
  axis_rms_t rms_want;
  int        error_count;
  int        hold_ticket;
  int        holds_served;
  bit        feed_bursty;
  bit        sink_bursty;

  three_axis_ema_window_rms_top #(
    .WINDOW_LENGTH (WINDOW),
    .FRACTION_BITS (FRAC_W),
    .SAMPLE_BITS   (SAMPLE_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    int          b;
    root = '0;
    for (b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if ({32'd0, trial} * {32'd0, trial} <= v) root = trial;
    end
    return root;
  endfunction

  task automatic clear_model();
    int a;
    int i;
    weight_q = WEIGHT_RESET;
    ring_pos = 0;
    for (a = 0; a < 3; a++) begin
      smooth_q[a] = '0;
      sum_sq_q[a] = '0;
      for (i = 0; i < WINDOW; i++) ring_q[a][i] = '0;
    end
  endtask

  // smooth one axis, push it into its ring and return the window rms
  function automatic logic [SMOOTH_W-1:0] axis_rms(input int a,
                                                   input logic [SAMPLE_W-1:0] raw);
    logic signed [63:0] target;
    logic signed [63:0] old;
    logic signed [63:0] prod;
    logic signed [63:0] step;
    logic signed [63:0] sum;
    logic [63:0]        gone;
    logic [63:0]        fresh;
    target = $signed({{(64-SMOOTH_W){1'b0}}, raw, {FRAC_W{1'b0}}});
    old    = $signed({{(64-SMOOTH_W){1'b0}}, smooth_q[a]});
    prod   = $signed({{(64-WEIGHT_BITS){1'b0}}, weight_q}) * (target - old);
    // floor division by 2^16
    step   = prod >>> WEIGHT_BITS;
    sum    = old + step;
    smooth_q[a] = sum[SMOOTH_W-1:0];
    gone  = {{(64-SMOOTH_W){1'b0}}, ring_q[a][ring_pos]};
    fresh = {{(64-SMOOTH_W){1'b0}}, smooth_q[a]};
    ring_q[a][ring_pos] = smooth_q[a];
    sum_sq_q[a] = sum_sq_q[a] - gone * gone + fresh * fresh;
    return floor_sqrt(sum_sq_q[a] / WINDOW);
  endfunction

  // expected rms triplet for every input transfer
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      rms_want[0] = axis_rms(0, s_axis_tdata_i[SAMPLE_W-1:0]);
      rms_want[1] = axis_rms(1, s_axis_tdata_i[2*SAMPLE_W-1:SAMPLE_W]);
      rms_want[2] = axis_rms(2, s_axis_tdata_i[3*SAMPLE_W-1:2*SAMPLE_W]);
      ring_pos = (ring_pos == WINDOW - 1) ? 0 : ring_pos + 1;
      expected_rms_q.push_back(rms_want);
    end
  end

  // ------------------------------------------------------------------ checker

  task automatic report_mismatch(input string what, input int a,
                                 input logic [SMOOTH_W-1:0] got,
                                 input logic [SMOOTH_W-1:0] want);
    if (error_count < PRINT_LIMIT)
      $display("MISMATCH %s axis %0d: got %h want %h at %0t", what, a, got, want, $time);
    error_count++;
  endtask

  // compare each output transfer with the oldest expected triplet
  always @(posedge clk_i) begin : rms_check
    axis_rms_t got;
    axis_rms_t want;
    int        a;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[3*SMOOTH_W-1:0];
      if (expected_rms_q.size() == 0) begin
        report_mismatch("unexpected result", 0, got[0], '0);
      end else begin
        want = expected_rms_q.pop_front();
        for (a = 0; a < 3; a++)
          if (got[a] !== want[a]) report_mismatch("rms", a, got[a], want[a]);
      end
    end
  end

  // ----------------------------------------------------------------- receiver

  // output ready: random stalls, or one long hold per ticket
  initial begin : rms_sink
    int n;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_ticket != holds_served) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_served <= holds_served + 1;
      end else if (sink_bursty && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        n = $urandom_range(1, 8);
        repeat (n - 1) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------- sender

  // offer one sample triplet and wait for its transfer
  task automatic send_sample(input logic [SAMPLE_W-1:0] x,
                             input logic [SAMPLE_W-1:0] y,
                             input logic [SAMPLE_W-1:0] z);
    int gap;
    s_axis_tdata_i  <= {{(IN_W-3*SAMPLE_W){1'b0}}, z, y, x};
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (feed_bursty && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering and wait for every expected result
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (expected_rms_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_weight(input logic [WEIGHT_BITS-1:0] w);
    drain_results();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    weight_q = w;
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return SAMPLE_MAX;
      default: return $urandom_range(0, SAMPLE_MAX);
    endcase
  endfunction

  // ------------------------------------------------------------------- tests

  task automatic test_reset_weight();
    send_sample('0, '0, '0);
    send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send_sample(SAMPLE_MAX, '0, 12'haaa);
    send_sample('0, SAMPLE_MAX, 12'h555);
  endtask

  task automatic test_fast_weight();
    write_weight(WEIGHT_MAX);
    send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send_sample(SAMPLE_MAX, '0, SAMPLE_MAX);
    send_sample('0, '0, '0);
    send_sample(12'haaa, 12'h555, 12'haaa);
    send_sample(12'h555, 12'haaa, 12'h555);
  endtask

  task automatic test_slow_weight();
    write_weight(16'd1);
    send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send_sample(SAMPLE_MAX, 12'h001, '0);
    send_sample('0, SAMPLE_MAX, 12'h800);
  endtask

  // weight zero freezes the smoothed values
  task automatic test_frozen_weight();
    write_weight('0);
    send_sample(SAMPLE_MAX, '0, 12'h4d2);
    send_sample('0, SAMPLE_MAX, 12'h7ff);
  endtask

  // random phases under different weights, wrapping the window many times
  task automatic test_random_phases();
    int                  phase;
    int                  i;
    int                  style;
    logic [SAMPLE_W-1:0] base [3];
    logic [WEIGHT_BITS-1:0] w;
    feed_bursty = 1'b1;
    sink_bursty <= 1'b1;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       w = WEIGHT_RESET;
        1:       w = WEIGHT_MAX;
        2:       w = 16'd1;
        default: w = $urandom_range(1, WEIGHT_MAX);
      endcase
      write_weight(w);
      style = $urandom_range(0, 1);
      for (i = 0; i < 3; i++) base[i] = $urandom_range(256, SAMPLE_MAX - 256);
      for (i = 0; i < 90; i++) begin
        if (style == 0)
          send_sample(random_sample(), random_sample(), random_sample());
        else
          // steady reading with a little noise
          send_sample(base[0] + $urandom_range(0, 255) - 128,
                      base[1] + $urandom_range(0, 255) - 128,
                      base[2] + $urandom_range(0, 255) - 128);
      end
    end
  endtask

  // output held off while the input keeps offering
  task automatic test_output_stall();
    int i;
    drain_results();
    feed_bursty = 1'b0;
    sink_bursty <= 1'b0;
    hold_ticket <= hold_ticket + 1;
    for (i = 0; i < 12; i++) send_sample(random_sample(), random_sample(), random_sample());
    drain_results();
  endtask

  // final stretch with no idling on either side
  task automatic test_back_to_back();
    int i;
    write_weight($urandom_range(1, WEIGHT_MAX));
    feed_bursty = 1'b0;
    sink_bursty <= 1'b0;
    for (i = 0; i < 80; i++) send_sample(random_sample(), random_sample(), random_sample());
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    s_axis_tdata_i  <= '0;
    s_axis_tvalid_i <= 1'b0;
    error_count  = 0;
    hold_ticket  = 0;
    holds_served = 0;
    feed_bursty  = 1'b1;
    sink_bursty  = 1'b1;
    clear_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_weight();
    test_fast_weight();
    test_slow_weight();
    test_frozen_weight();
    test_random_phases();
    test_output_stall();
    test_back_to_back();

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/emwr_pkg.sv
rtl/core/emwr_sqrt.sv
rtl/core/emwr_lane.sv
rtl/core/three_axis_ema_window_rms_top.sv
rtl/core/emwr_checker.sv
test/three_axis_ema_window_rms_top_tb.sv
